// ===== hw/rtl/sle_pkg.sv =====
// ----------------------------------------------------------------------------
// sle_pkg
// Shared types and constants of the serial line editor: character codes,
// result kinds, command format between front and back, back state codes.
// ----------------------------------------------------------------------------
package sle_pkg;

   localparam int LINE_CAPACITY_DEFAULT = 32;
   localparam int CMD_ARG_W             = 6;
   localparam int CMD_QUEUE_DEPTH       = 2;

   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_BS    = 8'h08;
   localparam logic [7:0] CHAR_DEL   = 8'h7F;
   localparam logic [7:0] CHAR_SPACE = 8'h20;

   typedef enum logic [1:0] {
      KIND_ECHO = 2'd0,
      KIND_LINE = 2'd1,
      KIND_END  = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      OP_STORE,
      OP_ERASE,
      OP_FLUSH
   } op_type;

   typedef struct packed {
      op_type               op;
      logic [7:0]           data;
      logic [CMD_ARG_W-1:0] arg;
   } cmd_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_WAIT,
      B_LINE,
      B_END,
      B_ERASE_SP,
      B_ERASE_BS
   } back_state_type;

endpackage

// ===== hw/rtl/sle_front.sv =====
// ----------------------------------------------------------------------------
// sle_front
// Accepts received bytes, tracks the character count and turns each byte
// into a store, erase or flush command; drops bytes that cause nothing.
// ----------------------------------------------------------------------------
module sle_front
   import sle_pkg::*;
#(
   parameter int LINE_CAPACITY = LINE_CAPACITY_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_rx_byte,
   output logic       cmd_push,
   output cmd_type    cmd_out,
   input  logic       cmd_full
);

   localparam int CNT_W = $clog2(LINE_CAPACITY);
   localparam logic [CNT_W-1:0] COUNT_LIMIT = CNT_W'(LINE_CAPACITY - 1);

   logic [CNT_W-1:0] count_ff, count_in;
   logic             accept;

   assign req_full = cmd_full;
   assign accept   = req_push && !cmd_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_comb begin
      count_in     = count_ff;
      cmd_push     = 1'b0;
      cmd_out.op   = OP_STORE;
      cmd_out.data = req_rx_byte;
      cmd_out.arg  = CMD_ARG_W'(count_ff);
      if (accept) begin
         if (req_rx_byte inside {CHAR_CR, CHAR_LF}) begin
            cmd_push   = 1'b1;
            cmd_out.op = OP_FLUSH;
            count_in   = '0;
         end else if (req_rx_byte inside {CHAR_BS, CHAR_DEL}) begin
            if (count_ff != '0) begin
               cmd_push   = 1'b1;
               cmd_out.op = OP_ERASE;
               count_in   = count_ff - 1'b1;
            end
         end else if (count_ff < COUNT_LIMIT) begin
            cmd_push = 1'b1;
            count_in = count_ff + 1'b1;
         end
      end
   end

endmodule

// ===== hw/rtl/sle_cmd_queue.sv =====
// ----------------------------------------------------------------------------
// sle_cmd_queue
// Short command queue between front and back.
// ----------------------------------------------------------------------------
module sle_cmd_queue
   import sle_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output cmd_type pop_cmd,
   output logic    empty
);

   localparam int PTR_W = $clog2(CMD_QUEUE_DEPTH);
   localparam int FILL_W = $clog2(CMD_QUEUE_DEPTH + 1);

   cmd_type           entries_ff [CMD_QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [FILL_W-1:0] fill_ff;
   logic              do_push, do_pop;

   assign full    = fill_ff == FILL_W'(CMD_QUEUE_DEPTH);
   assign empty   = fill_ff == '0;
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign pop_cmd = entries_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            fill_ff <= fill_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            fill_ff <= fill_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== hw/rtl/sle_back.sv =====
// ----------------------------------------------------------------------------
// sle_back
// Carries out commands: holds the line store, produces echo, line and
// end-of-line results into the result register.
// ----------------------------------------------------------------------------
module sle_back
   import sle_pkg::*;
#(
   parameter int LINE_CAPACITY = LINE_CAPACITY_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       cmd_empty,
   input  cmd_type    cmd_in,
   output logic       cmd_pop,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [1:0] rsp_out_kind,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last_of_run
);

   localparam int CNT_W = $clog2(LINE_CAPACITY);

   logic [7:0]       line_store [LINE_CAPACITY];
   logic [7:0]       rd_data_ff;
   back_state_type   state_ff, state_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] len_ff, len_in;
   logic             out_valid_ff, out_valid_in;
   kind_type         out_kind_ff;
   logic [7:0]       out_byte_ff;
   logic             out_last_ff;
   logic             slot_free, emit, emit_last, wr_en, last_line;
   kind_type         emit_kind;
   logic [7:0]       emit_byte;
   logic [CNT_W-1:0] cmd_len;

   assign slot_free       = !out_valid_ff || rsp_pop;
   assign cmd_len         = cmd_in.arg[CNT_W-1:0];
   assign last_line       = ({1'b0, idx_ff} + 1'b1) == {1'b0, len_ff};
   assign rsp_empty       = !out_valid_ff;
   assign rsp_out_kind    = out_kind_ff;
   assign rsp_out_byte    = out_byte_ff;
   assign rsp_last_of_run = out_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      len_ff <= len_in;
      if (emit) begin
         out_kind_ff <= emit_kind;
         out_byte_ff <= emit_byte;
         out_last_ff <= emit_last;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_store[cmd_len] <= cmd_in.data;
      end
      rd_data_ff <= line_store[idx_in];
   end

   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      len_in    = len_ff;
      cmd_pop   = 1'b0;
      wr_en     = 1'b0;
      emit      = 1'b0;
      emit_kind = KIND_ECHO;
      emit_byte = 8'h00;
      emit_last = 1'b0;
      case (state_ff)
         B_IDLE: begin
            if (!cmd_empty && slot_free) begin
               cmd_pop = 1'b1;
               case (cmd_in.op)
                  OP_STORE: begin
                     wr_en     = 1'b1;
                     emit      = 1'b1;
                     emit_byte = cmd_in.data;
                     emit_last = 1'b1;
                  end
                  OP_ERASE: begin
                     emit      = 1'b1;
                     emit_byte = CHAR_BS;
                     state_in  = B_ERASE_SP;
                  end
                  OP_FLUSH: begin
                     if (cmd_len == '0) begin
                        emit      = 1'b1;
                        emit_kind = KIND_END;
                        emit_last = 1'b1;
                     end else begin
                        len_in   = cmd_len;
                        idx_in   = '0;
                        state_in = B_WAIT;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         B_WAIT: begin
            state_in = B_LINE;
         end
         B_LINE: begin
            if (slot_free) begin
               emit      = 1'b1;
               emit_kind = KIND_LINE;
               emit_byte = rd_data_ff;
               if (last_line) begin
                  state_in = B_END;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         B_END: begin
            if (slot_free) begin
               emit      = 1'b1;
               emit_kind = KIND_END;
               emit_last = 1'b1;
               state_in  = B_IDLE;
            end
         end
         B_ERASE_SP: begin
            if (slot_free) begin
               emit      = 1'b1;
               emit_byte = CHAR_SPACE;
               state_in  = B_ERASE_BS;
            end
         end
         B_ERASE_BS: begin
            if (slot_free) begin
               emit      = 1'b1;
               emit_byte = CHAR_BS;
               emit_last = 1'b1;
               state_in  = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
      out_valid_in = emit || (out_valid_ff && !rsp_pop);
   end

endmodule

// ===== hw/rtl/serial_line_editor.sv =====
// ----------------------------------------------------------------------------
// serial_line_editor
// Editable command line fed one received byte per transaction, with echo,
// backspace erase and line flush on carriage return or line feed.
//
//   channel  ports                            transaction
//   req      req_push req_full req_rx_byte    push && !full
//   rsp      rsp_pop rsp_empty rsp_out_*      pop && !empty
//
// A stored byte or empty-line terminator gives its result through the command
// queue and the result register; an erase gives backspace, space, backspace.
// A flush of N stored bytes gives one line byte per cycle while the result
// slot is free, from the registered read of the line store, then an end marker.
// The front accepts while the two-entry command queue has room.
// Reset clears the character count, the queue and the result register.
// ----------------------------------------------------------------------------
module serial_line_editor
   import sle_pkg::*;
#(
   parameter int LINE_CAPACITY = LINE_CAPACITY_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [1:0] rsp_out_kind,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last_of_run
);

   cmd_type front_cmd, back_cmd;
   logic    q_push, q_full, q_pop, q_empty;

   sle_front #(
      .LINE_CAPACITY(LINE_CAPACITY)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_rx_byte (req_rx_byte),
      .cmd_push    (q_push),
      .cmd_out     (front_cmd),
      .cmd_full    (q_full)
   );

   sle_cmd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (front_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .pop_cmd  (back_cmd),
      .empty    (q_empty)
   );

   sle_back #(
      .LINE_CAPACITY(LINE_CAPACITY)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .cmd_empty       (q_empty),
      .cmd_in          (back_cmd),
      .cmd_pop         (q_pop),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_out_kind    (rsp_out_kind),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

// ===== hw/rtl/sle_checker.sv =====
// ----------------------------------------------------------------------------
// sle_checker
// Port-level checks of the serial line editor, bound to the top level.
// ----------------------------------------------------------------------------
module sle_checker
   import sle_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_push,
   input logic       req_full,
   input logic [7:0] req_rx_byte,
   input logic       rsp_empty,
   input logic       rsp_pop,
   input logic [1:0] rsp_out_kind,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_last_of_run
);

   a_reset_clear: assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full)
      else $error("queues not clear after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_out_kind)
         && $stable(rsp_out_byte) && $stable(rsp_last_of_run))
      else $error("stalled result changed");

   a_kind_legal: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> rsp_out_kind == KIND_ECHO || rsp_out_kind == KIND_LINE
         || rsp_out_kind == KIND_END)
      else $error("illegal result kind");

   a_end_last: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_out_kind == KIND_END |-> rsp_last_of_run
         && rsp_out_byte == 8'h00)
      else $error("end marker malformed");

   a_line_not_last: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_out_kind == KIND_LINE |-> !rsp_last_of_run)
      else $error("line byte flagged last");

endmodule

bind serial_line_editor sle_checker u_sle_checker (.*);
